[hw/rtl/tsq_pkg.sv]
// tsq_pkg: shared constants, operation codes and controller/datapath
// interface structs for the typed send queue. No dependencies.
package tsq_pkg;

  localparam int DEPTH = 10;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_POP     = 2'd1;
  localparam logic [1:0] OP_CLR_ALL = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // latch the incoming beat
    logic scan_clr;   // rewind the type search
    logic scan_inc;   // advance the type search
    logic drop_scan;  // drop the entry under the search pointer
    logic drop_head;  // drop the head entry
    logic append;     // append the latched entry at the tail
    logic clear;      // empty the queue
    logic result;     // capture the result flags
    logic accepted;   // accepted flag to capture
  } tsq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_end;   // search pointer has reached the count
    logic match;      // entry under the pointer has the latched type
    logic full;
    logic empty;
  } tsq_sts_t;

endpackage

[hw/rtl/tsq_datapath.sv]
// tsq_datapath: entry registers, count, search pointer and result flags.
// Depends on tsq_pkg.
module tsq_datapath
  import tsq_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  tsq_cmd_t       cmd,
  input  logic [7:0]     in_entry_type,
  input  logic [15:0]    in_payload_handle,
  input  logic           in_remove_same_type,
  output tsq_sts_t       sts,
  output logic           res_accepted,
  output logic           res_start_send,
  output logic [7:0]     head_type,
  output logic [15:0]    head_payload,
  output logic [3:0]     entry_count
);

  logic [7:0]       type_r [DEPTH];
  logic [15:0]      pay_r  [DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r;
  logic [7:0]       etype_r;
  logic [15:0]      handle_r;
  logic             before_zero_r;
  logic             acc_r, pulse_r;
  logic [CNT_W-1:0] drop_pos;
  logic             dropping;
  logic [CNT_W+3:0] count_ext;

  assign dropping = cmd.drop_scan | cmd.drop_head;
  assign drop_pos = cmd.drop_head ? '0 : idx_r;

  assign sts.scan_end = (idx_r >= count_r);
  assign sts.match    = (idx_r < count_r) && (type_r[idx_r[IDX_W-1:0]] == etype_r);
  assign sts.full     = (count_r == CNT_W'(DEPTH));
  assign sts.empty    = (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (dropping) begin
      count_nxt = count_r - 1'b1;
    end else if (cmd.append) begin
      count_nxt = count_r + 1'b1;
    end
  end

  // Entry shift and append; storage holds no reset
  always_ff @(posedge clk) begin
    for (int j = 0; j < DEPTH; j++) begin
      if (dropping && (CNT_W'(j) >= drop_pos) && (j + 1 < DEPTH)) begin
        type_r[j] <= type_r[(j + 1) % DEPTH];
        pay_r[j]  <= pay_r[(j + 1) % DEPTH];
      end else if (cmd.append && (count_r == CNT_W'(j))) begin
        type_r[j] <= etype_r;
        pay_r[j]  <= handle_r;
      end
    end
    if (cmd.load) begin
      etype_r       <= in_entry_type;
      handle_r      <= in_payload_handle;
      before_zero_r <= !in_remove_same_type || (count_r == '0);
    end
    if (cmd.result) begin
      acc_r   <= cmd.accepted;
      pulse_r <= cmd.append && (count_r == '0) && before_zero_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.scan_clr) begin
        idx_r <= '0;
      end else if (cmd.scan_inc) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  assign count_ext      = {4'b0, count_r};
  assign entry_count    = count_ext[3:0];
  assign head_type      = (count_r != '0) ? type_r[0] : 8'd0;
  assign head_payload   = (count_r != '0) ? pay_r[0] : 16'd0;
  assign res_accepted   = acc_r;
  assign res_start_send = pulse_r;

endmodule

[hw/rtl/tsq_ctrl.sv]
// tsq_ctrl: operation sequencer for the typed send queue.
// Depends on tsq_pkg.
module tsq_ctrl
  import tsq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_operation,
  input  logic       in_remove_same_type,
  input  tsq_sts_t   sts,
  output tsq_cmd_t   cmd,
  output logic       busy,
  output logic       out_valid
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [1:0] op_r;
  logic       valid_r;
  logic       take;

  assign take = start && !busy;
  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = ((in_operation == OP_ADD) && in_remove_same_type) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = ST_EXEC;
        end else if (sts.match) begin
          cmd.drop_scan = 1'b1;
          state_nxt     = ST_EXEC;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      ST_EXEC: begin
        cmd.result = 1'b1;
        state_nxt  = ST_IDLE;
        unique case (op_r)
          OP_ADD: begin
            cmd.append   = !sts.full;
            cmd.accepted = !sts.full;
          end
          OP_POP: begin
            cmd.drop_head = !sts.empty;
            cmd.accepted  = 1'b1;
          end
          OP_CLR_ALL: begin
            cmd.clear    = 1'b1;
            cmd.accepted = 1'b1;
          end
          default: cmd.accepted = 1'b0;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
      op_r    <= OP_ADD;
    end else begin
      state_r <= state_nxt;
      valid_r <= (state_r == ST_EXEC);
      if (take) begin
        op_r <= in_operation;
      end
    end
  end

  assign out_valid = valid_r;

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> busy) else $error("accepted beat did not raise busy");

  a_strobe_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_EXEC) else $error("result strobe without execute");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held over two cycles");

  a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.drop_scan && (cmd.drop_head || cmd.append || cmd.clear)))
    else $error("conflicting queue updates");

endmodule

[hw/rtl/typed_send_queue.sv]
// typed_send_queue: ordered send queue of DEPTH typed entries; add (optionally
// dropping the oldest entry of the same type first), pop head, clear all.
// The result strobe follows the execute state; an add with same-type removal
// first walks the search state over the entries until one matches or the count
// is reached. One beat in flight; busy drops with the strobe.
// Sync active-low reset empties the queue, not the entries; receiver cannot stall.
module typed_send_queue
  import tsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_entry_type,
  input  logic [15:0] in_payload_handle,
  input  logic        in_remove_same_type,
  output logic        out_valid,
  output logic        out_accepted,
  output logic [7:0]  out_head_type,
  output logic [15:0] out_head_payload,
  output logic [3:0]  out_entry_count,
  output logic        out_start_send
);

  tsq_cmd_t cmd;
  tsq_sts_t sts;

  // Sequencer: takes the beat, walks the type search one entry per cycle,
  // then issues the operation's queue update and raises the result strobe.
  tsq_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .in_operation        (in_operation),
    .in_remove_same_type (in_remove_same_type),
    .sts                 (sts),
    .cmd                 (cmd),
    .busy                (busy),
    .out_valid           (out_valid)
  );

  // Datapath: entry registers with a parallel shift-down for removal, the
  // fill count, the search pointer and the captured result flags. Head and
  // count are read straight from the registers after the update.
  tsq_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_entry_type       (in_entry_type),
    .in_payload_handle   (in_payload_handle),
    .in_remove_same_type (in_remove_same_type),
    .sts                 (sts),
    .res_accepted        (out_accepted),
    .res_start_send      (out_start_send),
    .head_type           (out_head_type),
    .head_payload        (out_head_payload),
    .entry_count         (out_entry_count)
  );

endmodule
